FILE: sv/nsd_pkg.sv
// nsd_pkg: shared types and constants of the netstring deframer
// no dependencies; used by the channel interfaces and every module

package nsd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned MAXLEN_W = 16;
  localparam int unsigned SUM_W    = MAXLEN_W + 1;

  localparam logic [BYTE_W-1:0]   CH_TILDE      = 8'h7E;
  localparam logic [BYTE_W-1:0]   CH_COLON      = 8'h3A;
  localparam logic [BYTE_W-1:0]   CH_DIGIT_LO   = 8'h30;
  localparam logic [BYTE_W-1:0]   CH_DIGIT_HI   = 8'h39;
  localparam logic [SUM_W-1:0]    LEN_SAT       = 17'h1_0000;
  localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 16'd4095;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_HEADER  = 2'd0,
    ERR_DIGITS  = 2'd1,
    ERR_TOO_LONG = 2'd2
  } err_t;

  typedef enum logic [4:0] {
    PH_HUNT_FRESH = 5'b00001,
    PH_HUNT_QUIET = 5'b00010,
    PH_LENGTH     = 5'b00100,
    PH_PAYLOAD    = 5'b01000,
    PH_TRAILER    = 5'b10000
  } phase_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_of_message;
    err_t              error_code;
  } res_t;

endpackage

FILE: sv/nsd_in_if.sv
// nsd_in_if: raw byte channel into the deframer
// depends on nsd_pkg

interface nsd_in_if import nsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: sv/nsd_out_if.sv
// nsd_out_if: result channel out of the deframer
// depends on nsd_pkg

interface nsd_out_if import nsd_pkg::*; ();
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [BYTE_W-1:0] payload_byte;
  logic              last_of_message;
  err_t              error_code;

  modport source (output valid, output kind, output payload_byte,
                  output last_of_message, output error_code, input ready);
  modport sink   (input valid, input kind, input payload_byte,
                  input last_of_message, input error_code, output ready);
endinterface

FILE: sv/nsd_cfg_if.sv
// nsd_cfg_if: write channel for the maximum payload length register
// depends on nsd_pkg

interface nsd_cfg_if import nsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MAXLEN_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/nsd_parser.sv
// nsd_parser: input register, framing state and per-byte decode
// depends on nsd_pkg and nsd_in_if

module nsd_parser import nsd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  nsd_in_if.sink              in_ch,
  input  logic [MAXLEN_W-1:0] max_len,
  output logic                res_valid,
  output res_t                res,
  input  logic                res_ready
);

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;

  phase_t              phase_r, phase_nxt;
  logic [SUM_W-1:0]    length_sum_r, length_sum_nxt;
  logic                digits_seen_r, digits_seen_nxt;
  logic [MAXLEN_W-1:0] bytes_left_r, bytes_left_nxt;

  logic             has_res;
  logic             s1_go;
  logic             is_digit;
  logic [20:0]      acc;
  logic             last;

  assign is_digit = (s1_byte_r >= CH_DIGIT_LO) && (s1_byte_r <= CH_DIGIT_HI);
  // sum*10 + digit as sum*8 + sum*2 + digit
  assign acc = 21'({length_sum_r, 3'b000}) + 21'({length_sum_r, 1'b0})
             + 21'(s1_byte_r[3:0]);
  assign last = (bytes_left_r <= 16'd1);

  always_comb begin
    phase_nxt       = phase_r;
    length_sum_nxt  = length_sum_r;
    digits_seen_nxt = digits_seen_r;
    bytes_left_nxt  = bytes_left_r;
    has_res         = 1'b0;
    res             = '{kind: KIND_PAYLOAD, payload_byte: '0,
                        last_of_message: 1'b0, error_code: ERR_HEADER};
    unique case (phase_r)
      PH_LENGTH: begin
        if (is_digit) begin
          length_sum_nxt  = (acc > 21'(LEN_SAT)) ? LEN_SAT : acc[SUM_W-1:0];
          digits_seen_nxt = 1'b1;
        end else if ((s1_byte_r != CH_COLON) || !digits_seen_r) begin
          phase_nxt      = PH_HUNT_QUIET;
          has_res        = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_DIGITS;
        end else if (length_sum_r > {1'b0, max_len}) begin
          phase_nxt      = PH_HUNT_QUIET;
          has_res        = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TOO_LONG;
        end else if (length_sum_r == '0) begin
          phase_nxt = PH_TRAILER;
          has_res   = 1'b1;
          res.kind  = KIND_EMPTY;
        end else begin
          bytes_left_nxt = length_sum_r[MAXLEN_W-1:0];
          phase_nxt      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        has_res             = 1'b1;
        res.kind            = KIND_PAYLOAD;
        res.payload_byte    = s1_byte_r;
        res.last_of_message = last;
        if (last) begin
          bytes_left_nxt = '0;
          phase_nxt      = PH_TRAILER;
        end else begin
          bytes_left_nxt = bytes_left_r - 16'd1;
        end
      end
      PH_TRAILER: begin
        phase_nxt = PH_HUNT_FRESH;
      end
      default: begin
        // hunting; junk reported once per run
        if (s1_byte_r == CH_TILDE) begin
          phase_nxt       = PH_LENGTH;
          length_sum_nxt  = '0;
          digits_seen_nxt = 1'b0;
        end else if (phase_r != PH_HUNT_QUIET) begin
          phase_nxt      = PH_HUNT_QUIET;
          has_res        = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_HEADER;
        end
      end
    endcase
  end

  // a byte with no result moves on even while the output is full
  assign s1_go       = s1_valid_r && (!has_res || res_ready);
  assign res_valid   = s1_valid_r && has_res;
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT_FRESH;
      length_sum_r  <= '0;
      digits_seen_r <= 1'b0;
      bytes_left_r  <= '0;
    end else if (s1_go) begin
      phase_r       <= phase_nxt;
      length_sum_r  <= length_sum_nxt;
      digits_seen_r <= digits_seen_nxt;
      bytes_left_r  <= bytes_left_nxt;
    end
  end

  a_payload_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> bytes_left_r != '0)
    else $error("payload phase with zero bytes left");

  a_length_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    length_sum_r <= LEN_SAT)
    else $error("length sum above saturation value");

  a_no_digits_no_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LENGTH && !digits_seen_r) |-> length_sum_r == '0)
    else $error("length sum nonzero before any digit");

  a_stalled_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_byte_r)
                                && $stable(phase_r)))
    else $error("stalled byte or state changed");

endmodule

FILE: sv/nsd_out_reg.sv
// nsd_out_reg: result register in front of the output channel
// depends on nsd_pkg and nsd_out_if

module nsd_out_reg import nsd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  res_valid,
  input  res_t  res,
  output logic  res_ready,
  nsd_out_if.source out_ch
);

  logic out_valid_r;
  res_t out_res_r;

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.kind            = out_res_r.kind;
  assign out_ch.payload_byte    = out_res_r.payload_byte;
  assign out_ch.last_of_message = out_res_r.last_of_message;
  assign out_ch.error_code      = out_res_r.error_code;

endmodule

FILE: sv/netstring_deframer.sv
// netstring_deframer: top level, length limit register and the two stages
// depends on nsd_pkg, the three channel interfaces, nsd_parser, nsd_out_reg

// Deframes a byte stream of messages laid out as '~', decimal length, ':',
// payload, one trailer byte. One byte is taken every clock cycle unless the
// stream stalls; a byte passes an input register and the decode logic, and
// its result, if any, is registered in the output register. Payload bytes
// come out one per beat with the last one marked, a zero length gives one
// empty-message beat, and framing faults give one error beat (junk before a
// header is reported once per run). Input ready follows output ready in the
// same cycle, so the stream only stalls while a result is waiting in a full
// output register. The length limit resets to 4095 and may be rewritten only
// while no message is in flight.

module netstring_deframer import nsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  nsd_in_if.sink    in_ch,
  nsd_out_if.source out_ch,
  nsd_cfg_if.sink   cfg_ch
);

  logic [MAXLEN_W-1:0] max_len_r;
  logic                res_valid;
  logic                res_ready;
  res_t                res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      max_len_r <= cfg_ch.data;
    end
  end

  nsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  nsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

endmodule
